/* hw/rtl/teees_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tree enter/exit event sequencer package
// Shared types, register indexes and the listener lookup helper.
// -----------------------------------------------------------------------------
package teees_pkg;

   localparam int NumKinds = 64;

   localparam logic CsrEnterMask = 1'b0;
   localparam logic CsrExitMask  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [15:0] node_index;
      logic [16:0] node_end;
      logic [5:0]  node_kind;
   } stack_entry_type;

   typedef struct packed {
      logic [5:0]  event_kind;
      logic        is_exit;
      logic [15:0] node_index;
      logic        last;
      logic        stack_overflow;
   } event_type;

   function automatic logic kind_enabled(input logic [63:0] mask, input logic [5:0] kind);
      logic hit;
      hit = 1'b0;
      if (7'(kind) < 7'(NumKinds)) begin
         hit = mask[kind];
      end
      return hit;
   endfunction

endpackage

/* hw/rtl/teees_stack.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Open node stack
// Storage for open nodes with one write port and two registered read ports,
// giving the top entry and the one below it.
// -----------------------------------------------------------------------------
module teees_stack #(
   parameter int STACK_DEPTH = 32,
   parameter int AW = 5
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  teees_pkg::stack_entry_type wr_data,
   input  logic [AW-1:0]              rd_top_addr,
   input  logic [AW-1:0]              rd_next_addr,
   output teees_pkg::stack_entry_type rd_top,
   output teees_pkg::stack_entry_type rd_next
);
   import teees_pkg::*;

   stack_entry_type mem [STACK_DEPTH];
   stack_entry_type rd_top_ff;
   stack_entry_type rd_next_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_top_ff  <= mem[rd_top_addr];
      rd_next_ff <= mem[rd_next_addr];
   end

   assign rd_top  = rd_top_ff;
   assign rd_next = rd_next_ff;

endmodule

/* hw/rtl/teees_out_reg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Event output register
// Holds one event beat for the receiver and frees as soon as it is taken.
// -----------------------------------------------------------------------------
module teees_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  teees_pkg::event_type load_data,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output teees_pkg::event_type out_data
);
   import teees_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   event_type data_ff;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/tree_enter_exit_event_sequencer.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tree enter/exit event sequencer
// Turns a preorder stream of tree nodes into enter and exit event beats.
// -----------------------------------------------------------------------------
// Each request beat is one preorder node (kind and subtree end) or an end of
// file marker. The block numbers nodes itself. For a node it first closes,
// innermost first, every open node whose subtree ends at the current index,
// then sends an enter beat if the kind has enter listeners, and then opens
// the node on the stack if the kind has exit listeners. End of file closes
// all open nodes and restarts numbering. rsp_last marks the final beat of a
// request, and rsp_stack_overflow reports a sticky overflow flag that end of
// file clears.
// A request is accepted in the idle state and then evaluated; after each exit
// beat the sequencer passes through a fetch state before it evaluates again,
// since each pop waits for a registered read of the stack memory. req_ready
// is high only while the sequencer is idle. A stalled receiver holds the
// sequencer in its evaluate step until the output register frees. Reset empties
// the stack, restarts numbering and clears the overflow flag and the listener
// masks. Masks must be written only while idle; the block does not enforce it.
// -----------------------------------------------------------------------------
module tree_enter_exit_event_sequencer #(
   parameter int STACK_DEPTH = 32,
   parameter int MAX_NODES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_node_kind,
   input  logic [16:0] req_subtree_end,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_event_kind,
   output logic        rsp_is_exit,
   output logic [15:0] rsp_node_index,
   output logic        rsp_last,
   output logic        rsp_stack_overflow,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import teees_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNTW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(MAX_NODES + 1);
   localparam int CW = (IW > 17) ? IW : 17;

   state_type       state_ff;
   state_type       state_in;
   logic [63:0]     enter_mask_ff;
   logic [63:0]     exit_mask_ff;
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] count_in;
   logic [IW-1:0]   next_idx_ff;
   logic [IW-1:0]   next_idx_in;
   logic            ovf_ff;
   logic            ovf_in;
   logic [5:0]      kind_ff;
   logic [16:0]     end_ff;
   logic            eof_ff;
   logic [IW-1:0]   idx_ff;

   stack_entry_type rd_top;
   stack_entry_type rd_next;
   stack_entry_type push_data;
   event_type       ev;
   event_type       out_data;

   logic accept_go;
   logic exhausted;
   logic enter_en;
   logic exit_en;
   logic top_match;
   logic next_match;
   logic pop_now;
   logic next_pop;
   logic enter_want;
   logic set_now;
   logic emit_need;
   logic out_free;
   logic step_go;
   logic load;
   logic push;
   logic finish;
   logic flag_now;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept_go = req_valid && req_ready;
   assign exhausted = (next_idx_ff >= IW'(MAX_NODES));

   assign enter_en   = kind_enabled(enter_mask_ff, kind_ff);
   assign exit_en    = kind_enabled(exit_mask_ff, kind_ff);
   assign top_match  = (CW'(rd_top.node_end) == CW'(idx_ff));
   assign next_match = (CW'(rd_next.node_end) == CW'(idx_ff));

   always_comb begin
      pop_now    = (count_ff != '0) && (eof_ff || top_match);
      next_pop   = (count_ff > CNTW'(1)) && (eof_ff || next_match);
      enter_want = !eof_ff && enter_en;
      set_now    = !eof_ff && exit_en && (count_ff == CNTW'(STACK_DEPTH)) && !pop_now;
      emit_need  = pop_now || enter_want;
      step_go    = (state_ff == ST_EVAL) && (!emit_need || out_free);
      load       = step_go && emit_need;
      push       = step_go && !pop_now && !eof_ff && exit_en &&
                   (count_ff < CNTW'(STACK_DEPTH));
      finish     = step_go && !pop_now;
      flag_now   = ovf_ff || set_now;
   end

   always_comb begin
      if (pop_now) begin
         ev.event_kind = rd_top.node_kind;
         ev.is_exit    = 1'b1;
         ev.node_index = rd_top.node_index;
         ev.last       = !next_pop && !enter_want;
      end else begin
         ev.event_kind = kind_ff;
         ev.is_exit    = 1'b0;
         ev.node_index = 16'(idx_ff);
         ev.last       = 1'b1;
      end
      ev.stack_overflow = flag_now;
   end

   always_comb begin
      push_data.node_index = 16'(idx_ff);
      push_data.node_end   = end_ff;
      push_data.node_kind  = kind_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_go && (req_end_of_file || !exhausted)) begin
               state_in = ST_EVAL;
            end
         end
         ST_FETCH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (step_go) begin
               state_in = pop_now ? ST_FETCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (step_go && pop_now) begin
         count_in = count_ff - CNTW'(1);
      end else if (push) begin
         count_in = count_ff + CNTW'(1);
      end else if (finish && eof_ff) begin
         count_in = '0;
      end

      next_idx_in = next_idx_ff;
      if (accept_go) begin
         if (req_end_of_file) begin
            next_idx_in = '0;
         end else if (!exhausted) begin
            next_idx_in = next_idx_ff + IW'(1);
         end
      end

      ovf_in = ovf_ff;
      if (finish && eof_ff) begin
         ovf_in = 1'b0;
      end else if (state_ff == ST_EVAL) begin
         ovf_in = flag_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         next_idx_ff   <= '0;
         ovf_ff        <= 1'b0;
         enter_mask_ff <= '0;
         exit_mask_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         next_idx_ff <= next_idx_in;
         ovf_ff      <= ovf_in;
         if (csr_wr_en) begin
            case (csr_index)
               CsrEnterMask: enter_mask_ff <= csr_wdata;
               CsrExitMask:  exit_mask_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_go) begin
         kind_ff <= req_node_kind;
         end_ff  <= req_subtree_end;
         eof_ff  <= req_end_of_file;
         idx_ff  <= next_idx_ff;
      end
   end

   teees_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_stack (
      .clock        (clock),
      .wr_en        (push),
      .wr_addr      (AW'(count_ff)),
      .wr_data      (push_data),
      .rd_top_addr  (AW'(count_ff - CNTW'(1))),
      .rd_next_addr (AW'(count_ff - CNTW'(2))),
      .rd_top       (rd_top),
      .rd_next      (rd_next)
   );

   teees_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (ev),
      .free      (out_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_event_kind     = out_data.event_kind;
   assign rsp_is_exit        = out_data.is_exit;
   assign rsp_node_index     = out_data.node_index;
   assign rsp_last           = out_data.last;
   assign rsp_stack_overflow = out_data.stack_overflow;

endmodule

/* tb/tree_enter_exit_event_sequencer_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tree enter/exit event sequencer testbench
// Drives preorder node streams and checks every enter and exit event beat.
// -----------------------------------------------------------------------------
// A short table of directed requests comes first: reset state, field extremes,
// nested exits, a full stack with the sticky overflow flag, and listeners on
// the top kind code. Random preorder files follow, mostly well formed
// with some corrupted ends and truncated files, under four listener mask
// settings and four idling mixes. Every accepted request runs through an
// in-bench model of the node stack, and each event beat is compared with the
// oldest predicted one.
// -----------------------------------------------------------------------------
module tree_enter_exit_event_sequencer_tb;
   import teees_pkg::*;

   localparam int STACK_SLOTS = 32;
   localparam int NODE_LIMIT = 65536;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum logic [1:0] {ROW_NODE, ROW_EOF, ROW_CSR} row_op_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_ONE} row_check_type;

   typedef struct packed {
      row_op_type    op;
      logic [5:0]    kind;
      logic [16:0]   end_idx;
      logic [15:0]   reps;
      logic          csr_sel;
      logic [63:0]   csr_value;
      row_check_type check;
      event_type     event_want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [5:0]  req_node_kind = '0;
   logic [16:0] req_subtree_end = '0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_event_kind;
   logic        rsp_is_exit;
   logic [15:0] rsp_node_index;
   logic        rsp_last;
   logic        rsp_stack_overflow;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [63:0] csr_wdata = '0;

   // Stack model state.
   logic [63:0] enter_mask = '0;
   logic [63:0] exit_mask = '0;
   logic [5:0]  open_kind [STACK_SLOTS];
   logic [15:0] open_index [STACK_SLOTS];
   logic [16:0] open_end [STACK_SLOTS];
   int          open_depth = 0;
   int unsigned next_index = 0;
   logic        overflow_seen = 1'b0;

   event_type   step_events [$];
   event_type   due_events [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int overflow_beats = 0;
   int mask_writes = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   stim_row_type plan [25] = '{
      '{ROW_NODE, 6'd0, 17'd1, 16'd1, CsrEnterMask, 64'd0, CHECK_NONE, '0},
      '{ROW_EOF, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_NONE, '0},
      '{ROW_CSR, 6'd0, 17'd0, 16'd1, CsrEnterMask, '1, CHECK_NONE, '0},
      '{ROW_NODE, 6'd63, 17'd65536, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd63, 1'b0, 16'd0, 1'b1, 1'b0}},
      '{ROW_NODE, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd0, 1'b0, 16'd1, 1'b1, 1'b0}},
      '{ROW_EOF, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_NONE, '0},
      '{ROW_CSR, 6'd0, 17'd0, 16'd1, CsrExitMask, '1, CHECK_NONE, '0},
      '{ROW_NODE, 6'd5, 17'd4, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_NODE, 6'd6, 17'd3, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_NODE, 6'd7, 17'd3, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_NODE, 6'd8, 17'd65536, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_NODE, 6'd9, 17'd5, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_NODE, 6'd10, 17'd6, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_EOF, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_CSR, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'h2, CHECK_NONE, '0},
      '{ROW_NODE, 6'd0, 17'd65536, 16'd32, CsrEnterMask, 64'd0, CHECK_NONE, '0},
      '{ROW_NODE, 6'd1, 17'd40, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd1, 1'b0, 16'd32, 1'b1, 1'b1}},
      '{ROW_NODE, 6'd2, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_NONE, '0},
      '{ROW_EOF, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_MODEL, '0},
      '{ROW_NODE, 6'd1, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd1, 1'b0, 16'd0, 1'b1, 1'b0}},
      '{ROW_EOF, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd1, 1'b1, 16'd0, 1'b1, 1'b0}},
      '{ROW_CSR, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'h8000_0000_0000_0000, CHECK_NONE, '0},
      '{ROW_CSR, 6'd0, 17'd0, 16'd1, CsrExitMask, 64'h8000_0000_0000_0000, CHECK_NONE, '0},
      '{ROW_NODE, 6'd63, 17'd65536, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd63, 1'b0, 16'd0, 1'b1, 1'b0}},
      '{ROW_EOF, 6'd0, 17'd0, 16'd1, CsrEnterMask, 64'd0, CHECK_ONE,
        '{6'd63, 1'b1, 16'd0, 1'b1, 1'b0}}
   };

   tree_enter_exit_event_sequencer #(
      .STACK_DEPTH(STACK_SLOTS),
      .MAX_NODES(NODE_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_node_kind(req_node_kind),
      .req_subtree_end(req_subtree_end),
      .req_end_of_file(req_end_of_file),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_is_exit(rsp_is_exit),
      .rsp_node_index(rsp_node_index),
      .rsp_last(rsp_last),
      .rsp_stack_overflow(rsp_stack_overflow),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_event(logic [5:0] kind, logic is_exit, logic [15:0] index);
      event_type ev;
      ev = '0;
      ev.event_kind = kind;
      ev.is_exit = is_exit;
      ev.node_index = index;
      step_events.push_back(ev);
   endfunction

   function automatic void close_top();
      open_depth--;
      add_event(open_kind[open_depth], 1'b1, open_index[open_depth]);
   endfunction

   // Works out the event beats of one request and advances the stack model.
   function automatic void sequence_events(logic [5:0] kind, logic [16:0] end_idx, logic eof);
      int unsigned here;
      step_events.delete();
      if (eof) begin
         while (open_depth > 0) close_top();
         next_index = 0;
      end else if (next_index < NODE_LIMIT) begin
         here = next_index;
         next_index++;
         while (open_depth > 0 && int'(open_end[open_depth - 1]) == here) close_top();
         if (int'(kind) < NumKinds && enter_mask[kind]) begin
            add_event(kind, 1'b0, 16'(here));
         end
         if (int'(kind) < NumKinds && exit_mask[kind]) begin
            if (open_depth < STACK_SLOTS) begin
               open_kind[open_depth] = kind;
               open_index[open_depth] = 16'(here);
               open_end[open_depth] = end_idx;
               open_depth++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
      end
      foreach (step_events[k]) begin
         step_events[k].stack_overflow = overflow_seen;
         step_events[k].last = (k == step_events.size() - 1);
      end
      if (eof) overflow_seen = 1'b0;
   endfunction

   function automatic void note_mismatch(string what, event_type want, event_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: want kind %0d exit %0b index %0d last %0b ovf %0b",
                  $time, what, want.event_kind, want.is_exit, want.node_index, want.last,
                  want.stack_overflow);
         $display("%0t %s: got kind %0d exit %0b index %0d last %0b ovf %0b",
                  $time, what, got.event_kind, got.is_exit, got.node_index, got.last,
                  got.stack_overflow);
      end
   endfunction

   task automatic send_item(input logic [5:0] kind, input logic [16:0] end_idx, input logic eof,
                            input row_check_type check, input event_type wanted);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_node_kind <= kind;
      req_subtree_end <= end_idx;
      req_end_of_file <= eof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      sequence_events(kind, end_idx, eof);
      case (check)
         CHECK_MODEL: begin
            foreach (step_events[k]) due_events.push_back(step_events[k]);
         end
         CHECK_ONE: begin
            due_events.push_back(wanted);
         end
         default: begin
         end
      endcase
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_events.size() != 0);
   endtask

   task automatic settle_block();
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic sel, input logic [63:0] value);
      settle_block();
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (sel == CsrEnterMask) enter_mask = value;
      else exit_mask = value;
      mask_writes++;
   endtask

   // One preorder file built from a random rightmost path, so that the subtree
   // ends are consistent. Some files get corrupted ends or are cut short.
   task automatic send_random_file();
      int n;
      int sent;
      int pick;
      int base;
      int path_len;
      int pops;
      int end_v;
      int path [48];
      int file_end [48];
      logic [5:0] kinds [48];
      bit deep;
      bit noisy;
      pick = $urandom_range(0, 9);
      if (pick < 7) n = $urandom_range(1, 10);
      else if (pick < 9) n = $urandom_range(11, 24);
      else n = $urandom_range(33, 48);
      deep = (n >= 33);
      noisy = ($urandom_range(0, 19) == 0);
      base = next_index;
      path_len = 0;
      for (int i = 0; i < n; i++) begin
         pops = (i == 0 || deep) ? 0 : $urandom_range(0, path_len);
         repeat (pops) begin
            path_len--;
            file_end[path[path_len]] = base + i;
         end
         path[path_len] = i;
         path_len++;
         kinds[i] = 6'($urandom_range(0, 63));
      end
      while (path_len > 0) begin
         path_len--;
         file_end[path[path_len]] = base + n;
      end
      sent = noisy ? $urandom_range(1, n) : n;
      for (int i = 0; i < sent; i++) begin
         end_v = file_end[i];
         if (noisy || $urandom_range(0, 9) == 0) begin
            end_v = ($urandom_range(0, 7) == 0) ? 65536 : $urandom_range(0, 65536);
         end
         send_item(kinds[i], 17'(end_v), 1'b0, CHECK_MODEL, '0);
      end
      if ($urandom_range(0, 3) != 0) begin
         send_item(6'($urandom_range(0, 63)), 17'($urandom_range(0, 65536)), 1'b1,
                   CHECK_MODEL, '0);
      end
   endtask

   always @(posedge clock) begin : receiver
      int hold_served;
      int hold_left;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : beat_check
      event_type seen;
      event_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_event_kind, rsp_is_exit, rsp_node_index, rsp_last, rsp_stack_overflow};
         beats_checked++;
         if (rsp_stack_overflow) overflow_beats++;
         if (due_events.size() == 0) begin
            note_mismatch("beat with no event due", '0, seen);
         end else begin
            due = due_events.pop_front();
            if (seen !== due) note_mismatch("event differs", due, seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no beat for %0d cycles, %0d events still due",
               WATCHDOG_LIMIT, due_events.size());
      $display("tree_enter_exit_event_sequencer_tb: errors");
      $finish;
   end

   initial begin
      int item_mark;
      int beat_mark;
      int files;
      logic [63:0] enter_pick;
      logic [63:0] exit_pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 25;
      stall_pct = 25;
      foreach (plan[r]) begin
         if (plan[r].op == ROW_CSR) begin
            write_mask(plan[r].csr_sel, plan[r].csr_value);
         end else begin
            repeat (plan[r].reps) begin
               send_item(plan[r].kind, plan[r].end_idx, plan[r].op == ROW_EOF,
                         plan[r].check, plan[r].event_want);
            end
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               enter_pick = {$urandom, $urandom};
               exit_pick = {$urandom, $urandom};
            end
            1: begin
               enter_pick = '1;
               exit_pick = '1;
            end
            2: begin
               enter_pick = '0;
               exit_pick = '1;
            end
            default: begin
               enter_pick = {$urandom, $urandom} & {$urandom, $urandom};
               exit_pick = {$urandom, $urandom} & {$urandom, $urandom};
            end
         endcase
         // End of file flushes the stack so the new masks start from a clean file.
         send_item(6'd0, 17'd0, 1'b1, CHECK_MODEL, '0);
         write_mask(CsrEnterMask, enter_pick);
         write_mask(CsrExitMask, exit_pick);
         send_idle_pct = (phase == 1) ? 71 : (phase == 3) ? 25 : 0;
         stall_pct = (phase == 2) ? 71 : (phase == 3) ? 25 : 0;
         item_mark = items_sent;
         beat_mark = beats_checked;
         files = 0;
         while ((items_sent - item_mark < 35 || beats_checked - beat_mark < 15) &&
                items_sent - item_mark < 400) begin
            send_random_file();
            files++;
            if (phase == 0 && files == 2) hold_requests++;
            if (phase == 2 && (files == 1 || $urandom_range(0, 3) == 0)) await_results();
         end
      end

      settle_block();
      $display("run covered %0d requests and %0d event beats, %0d of them with overflow set",
               items_sent, beats_checked, overflow_beats);
      $display("listener mask writes: %0d, including a receiver hold-off and drain pauses",
               mask_writes);
      if (mismatches == 0) begin
         $display("tree_enter_exit_event_sequencer_tb: clean");
      end else begin
         $display("tree_enter_exit_event_sequencer_tb: errors");
      end
      $finish;
   end

endmodule
